>>> design/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared constants, codes and control types of the separable box blur.
// ----------------------------------------------------------------------------
package sbb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 8;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int HW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HHW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int DW   = $clog2(2 * MAX_RADIUS + 2);
  localparam int SW   = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int RB   = $clog2(2 * MAX_RADIUS + 2);
  localparam int AW   = RB + CW;
  localparam int PW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DEPTH = 1 << AW;

  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 11;
  localparam logic [CFG_IW-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    logic          clr_h;
    logic          clr_v;
    logic          div_start;
    logic          div_final;
    logic [DW-1:0] divisor;
  } sbb_cmd_t;

  typedef struct packed {
    logic div_done;
  } sbb_stat_t;

endpackage

>>> design/sbb_ram.sv
// ----------------------------------------------------------------------------
// sbb_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/sbb_dp.sv
// ----------------------------------------------------------------------------
// sbb_dp
// Blur datapath: pixel store, window accumulators and shared serial divider.
// ----------------------------------------------------------------------------
module sbb_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sbb_pkg::sbb_cmd_t cmd,
  input  logic [23:0]       pix_in,
  output sbb_pkg::sbb_stat_t stat,
  output logic [23:0]       rgb_out
);

  logic [23:0]             rdata;
  logic                    rdv_r;
  logic [sbb_pkg::SW-1:0]  hs_r [3];
  logic [sbb_pkg::SW-1:0]  vs_r [3];
  logic [7:0]              res_r [3];
  logic                    busy_r;
  logic                    final_r;
  logic [1:0]              ch_r;
  logic [$clog2(sbb_pkg::SW+1)-1:0] cnt_r;
  logic [sbb_pkg::DW-1:0]  rem_r;
  logic [sbb_pkg::SW-1:0]  dvd_r;
  logic                    done_r;
  logic [sbb_pkg::DW:0]    trial;
  logic                    ge;
  logic [sbb_pkg::DW-1:0]  rem_nxt;
  logic [sbb_pkg::SW-1:0]  dvd_nxt;
  logic [sbb_pkg::SW-1:0]  next_src;

  sbb_ram #(.WIDTH(24), .DEPTH(sbb_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .re    (cmd.re),
    .addr  (cmd.addr),
    .wdata (pix_in),
    .rdata (rdata)
  );

  assign trial   = {rem_r, dvd_r[sbb_pkg::SW-1]};
  assign ge      = trial >= {1'b0, cmd.divisor};
  assign rem_nxt = ge ? sbb_pkg::DW'(trial - {1'b0, cmd.divisor})
                      : sbb_pkg::DW'(trial);
  assign dvd_nxt = {dvd_r[sbb_pkg::SW-2:0], ge};

  always_comb begin
    case (ch_r)
      2'd0:    next_src = final_r ? vs_r[1] : hs_r[1];
      default: next_src = final_r ? vs_r[2] : hs_r[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r  <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      rdv_r  <= cmd.re;
      done_r <= 1'b0;
      if (cmd.clr_h) begin
        for (int k = 0; k < 3; k++) hs_r[k] <= '0;
      end else if (rdv_r) begin
        for (int k = 0; k < 3; k++) hs_r[k] <= hs_r[k] + sbb_pkg::SW'(rdata[8*k +: 8]);
      end
      if (cmd.clr_v) begin
        for (int k = 0; k < 3; k++) vs_r[k] <= '0;
      end
      if (cmd.div_start) begin
        busy_r  <= 1'b1;
        final_r <= cmd.div_final;
        ch_r    <= 2'd0;
        cnt_r   <= '0;
        rem_r   <= '0;
        dvd_r   <= cmd.div_final ? vs_r[0] : hs_r[0];
      end else if (busy_r) begin
        if (cnt_r == ($bits(cnt_r))'(sbb_pkg::SW - 1)) begin
          if (final_r) begin
            res_r[ch_r] <= dvd_nxt[7:0];
          end else begin
            vs_r[ch_r] <= vs_r[ch_r] + sbb_pkg::SW'(dvd_nxt[7:0]);
          end
          cnt_r <= '0;
          rem_r <= '0;
          if (ch_r == 2'd2) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            ch_r  <= ch_r + 2'd1;
            dvd_r <= next_src;
          end
        end else begin
          cnt_r <= cnt_r + 1'b1;
          rem_r <= rem_nxt;
          dvd_r <= dvd_nxt;
        end
      end
    end
  end

  assign stat.div_done = done_r;
  assign rgb_out = {res_r[2], res_r[1], res_r[0]};

endmodule

>>> design/sbb_ctrl.sv
// ----------------------------------------------------------------------------
// sbb_ctrl
// Blur controller: config, frame positions, window sequencing, output beat.
// ----------------------------------------------------------------------------
module sbb_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        mode,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [9:0]                  column,
  output logic [9:0]                  row,
  output logic                        frame_done,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sbb_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sbb_pkg::CFG_DW-1:0]  cfg_data,
  output sbb_pkg::sbb_cmd_t           cmd,
  input  sbb_pkg::sbb_stat_t          stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROW, S_READ, S_DRAIN, S_RDIV, S_RWAIT, S_FDIV, S_FWAIT
  } state_t;

  state_t                 state_r;
  logic [3:0]             radius_r;
  logic [10:0]            width_r;
  logic [10:0]            height_r;
  logic [sbb_pkg::PW-1:0] in_pos_r, out_pos_r;
  logic [sbb_pkg::CW-1:0] in_col_r, out_col_r, res_col_r;
  logic [sbb_pkg::HW-1:0] in_row_r, out_row_r, res_row_r;
  logic                   res_last_r;
  logic                   out_valid_r;
  logic [sbb_pkg::DW-1:0] dy_r, dx_r;

  logic [sbb_pkg::RW-1:0]  rad;
  logic [sbb_pkg::WW-1:0]  w;
  logic [sbb_pkg::HHW-1:0] h;
  logic [sbb_pkg::PW-1:0]  total, lag;
  logic [sbb_pkg::DW-1:0]  span;
  logic                    in_acc, push, emit_go, cfg_acc, out_free;
  logic signed [sbb_pkg::CW+1:0] xs;
  logic signed [sbb_pkg::HW+1:0] ys;
  logic [sbb_pkg::CW-1:0]  cx;
  logic [sbb_pkg::HW-1:0]  ry;

  assign rad = (radius_r > 4'(sbb_pkg::MAX_RADIUS)) ? sbb_pkg::RW'(sbb_pkg::MAX_RADIUS)
                                                    : sbb_pkg::RW'(radius_r);
  assign w = (width_r == 11'd0) ? sbb_pkg::WW'(1) :
             (32'(width_r) > sbb_pkg::MAX_WIDTH) ? sbb_pkg::WW'(sbb_pkg::MAX_WIDTH)
                                                 : sbb_pkg::WW'(width_r);
  assign h = (height_r == 11'd0) ? sbb_pkg::HHW'(1) :
             (32'(height_r) > sbb_pkg::MAX_HEIGHT) ? sbb_pkg::HHW'(sbb_pkg::MAX_HEIGHT)
                                                   : sbb_pkg::HHW'(height_r);
  assign total = sbb_pkg::PW'(w) * sbb_pkg::PW'(h);
  assign lag   = sbb_pkg::PW'(rad) * sbb_pkg::PW'(w) + sbb_pkg::PW'(rad);
  assign span  = sbb_pkg::DW'({rad, 1'b0});

  // result slot is free, or its beat is taken at this edge
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign push      = in_acc && !mode && (in_pos_r < total);
  assign emit_go   = push ? (in_pos_r >= lag)
                          : (in_acc && (in_pos_r == total) && (out_pos_r < total));
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready &&
                     (cfg_index == sbb_pkg::CFG_RADIUS || cfg_index == sbb_pkg::CFG_WIDTH ||
                      cfg_index == sbb_pkg::CFG_HEIGHT);

  always_comb begin
    xs = $signed((sbb_pkg::CW+2)'(out_col_r)) + $signed((sbb_pkg::CW+2)'(dx_r))
         - $signed((sbb_pkg::CW+2)'(rad));
    ys = $signed((sbb_pkg::HW+2)'(out_row_r)) + $signed((sbb_pkg::HW+2)'(dy_r))
         - $signed((sbb_pkg::HW+2)'(rad));
    if (xs[sbb_pkg::CW+1]) cx = '0;
    else if (xs >= $signed((sbb_pkg::CW+2)'(w))) cx = sbb_pkg::CW'(w - 1'b1);
    else cx = sbb_pkg::CW'(xs);
    if (ys[sbb_pkg::HW+1]) ry = '0;
    else if (ys >= $signed((sbb_pkg::HW+2)'(h))) ry = sbb_pkg::HW'(h - 1'b1);
    else ry = sbb_pkg::HW'(ys);
  end

  always_comb begin
    cmd.we        = push;
    cmd.re        = (state_r == S_READ);
    cmd.addr      = push ? {in_row_r[sbb_pkg::RB-1:0], in_col_r}
                         : {ry[sbb_pkg::RB-1:0], cx};
    cmd.clr_h     = (state_r == S_ROW);
    cmd.clr_v     = in_acc && emit_go;
    cmd.div_start = (state_r == S_RDIV) || ((state_r == S_FDIV) && out_free);
    cmd.div_final = (state_r == S_FDIV);
    cmd.divisor   = sbb_pkg::DW'({rad, 1'b1});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      radius_r    <= 4'd1;
      width_r     <= 11'd640;
      height_r    <= 11'd480;
      in_pos_r    <= '0;
      out_pos_r   <= '0;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_valid_r <= 1'b0;
      dy_r        <= '0;
      dx_r        <= '0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cfg_acc) begin
        case (cfg_index)
          sbb_pkg::CFG_RADIUS: radius_r <= cfg_data[3:0];
          sbb_pkg::CFG_WIDTH:  width_r  <= cfg_data;
          default:             height_r <= cfg_data;
        endcase
        in_pos_r  <= '0;
        out_pos_r <= '0;
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (push) begin
            in_pos_r <= in_pos_r + 1'b1;
            if (sbb_pkg::WW'(in_col_r) == w - 1'b1) begin
              in_col_r <= '0;
              in_row_r <= in_row_r + 1'b1;
            end else begin
              in_col_r <= in_col_r + 1'b1;
            end
          end
          if (emit_go) begin
            dy_r    <= '0;
            state_r <= S_ROW;
          end
        end
        S_ROW: begin
          dx_r    <= '0;
          state_r <= S_READ;
        end
        S_READ: begin
          if (dx_r == span) state_r <= S_DRAIN;
          else dx_r <= dx_r + 1'b1;
        end
        S_DRAIN: state_r <= S_RDIV;
        S_RDIV:  state_r <= S_RWAIT;
        S_RWAIT: begin
          if (stat.div_done) begin
            if (dy_r == span) begin
              state_r <= S_FDIV;
            end else begin
              dy_r    <= dy_r + 1'b1;
              state_r <= S_ROW;
            end
          end
        end
        S_FDIV: begin
          if (out_free) state_r <= S_FWAIT;
        end
        S_FWAIT: begin
          if (stat.div_done) begin
            out_valid_r <= 1'b1;
            res_col_r   <= out_col_r;
            res_row_r   <= out_row_r;
            res_last_r  <= (out_pos_r + 1'b1 == total);
            if (out_pos_r + 1'b1 >= total) begin
              out_pos_r <= '0;
              in_pos_r  <= '0;
              out_col_r <= '0;
              out_row_r <= '0;
              in_col_r  <= '0;
              in_row_r  <= '0;
            end else begin
              out_pos_r <= out_pos_r + 1'b1;
              if (sbb_pkg::WW'(out_col_r) == w - 1'b1) begin
                out_col_r <= '0;
                out_row_r <= out_row_r + 1'b1;
              end else begin
                out_col_r <= out_col_r + 1'b1;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign column     = 10'(res_col_r);
  assign row        = 10'(res_row_r);
  assign frame_done = res_last_r;

`ifndef ASSERT_OFF
  a_out_pos: assert property (@(posedge clk) disable iff (!rst_n) out_pos_r < total)
    else $error("output position past frame");
  a_in_pos: assert property (@(posedge clk) disable iff (!rst_n) in_pos_r <= total)
    else $error("input position past frame");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FWAIT && stat.div_done) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result beat not raised after final divide");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input taken while busy");
`endif

endmodule

>>> design/separable_box_blur_rgb.sv
// ----------------------------------------------------------------------------
// separable_box_blur_rgb
// RGB separable box blur with clamped edges over a raster pixel stream.
// ----------------------------------------------------------------------------
// One beat at a time. A push that emits no pixel only stores it; a beat that
// emits a pixel also reads its window one pixel per cycle from the single-port
// pixel RAM and runs the shared bit-serial divider on sums that are SW = 13
// bits wide for the default maximum radius.
// A new input beat is taken whenever the controller is idle; the final divide
// of an emitting beat waits until the previous result beat has been taken.
// ----------------------------------------------------------------------------
module separable_box_blur_rgb (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // red_in, green_in, blue_in
  input  logic                       in_tuser,   // mode
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [47:0]                out_tdata,  // red, green, blue, column, row, pad
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [sbb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sbb_pkg::CFG_DW-1:0] cfg_data
);

  sbb_pkg::sbb_cmd_t  cmd;
  sbb_pkg::sbb_stat_t stat;
  logic [23:0]        rgb;
  logic [9:0]         column, row;

  sbb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .mode       (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .column     (column),
    .row        (row),
    .frame_done (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat)
  );

  sbb_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .pix_in  (in_tdata),
    .stat    (stat),
    .rgb_out (rgb)
  );

  assign out_tdata = {4'b0, row, column, rgb};

endmodule
